@@ rtl/core/ps2sa_pkg.sv @@
// ps2sa_pkg: shared types, constants and the set 2 to ascii lookup
`default_nettype none

package ps2sa_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [ByteW-1:0] ScanExt0 = 8'hE0;
  localparam logic [ByteW-1:0] ScanExt1 = 8'hE1;
  localparam logic [ByteW-1:0] ScanRelease = 8'hF0;
  localparam logic [ByteW-1:0] TableLen = 8'h77;
  localparam logic [ByteW-1:0] CaseDelta = 8'd32;
  localparam logic [ByteW-1:0] AsciiLowA = 8'h61;
  localparam logic [ByteW-1:0] AsciiLowZ = 8'h7A;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEFT_SHIFT_SCAN  = 3'd0,
    CFG_RIGHT_SHIFT_SCAN = 3'd1,
    CFG_CAPS_SCAN        = 3'd2,
    CFG_LEFT_SHIFT_KEY   = 3'd3,
    CFG_RIGHT_SHIFT_KEY  = 3'd4,
    CFG_CAPS_KEY         = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] left_shift_scan;
    logic [ByteW-1:0] right_shift_scan;
    logic [ByteW-1:0] caps_scan;
    logic [ByteW-1:0] left_shift_key;
    logic [ByteW-1:0] right_shift_key;
    logic [ByteW-1:0] caps_key;
  } cfg_t;

  function automatic logic [ByteW-1:0] set2_ascii(input logic [6:0] code);
    logic [ByteW-1:0] r;
    r = '0;
    case (code)
      7'h0d: r = 8'd9;
      7'h0e: r = 8'h60;
      7'h15: r = "q";
      7'h16: r = "1";
      7'h1a: r = "z";
      7'h1b: r = "s";
      7'h1c: r = "a";
      7'h1d: r = "w";
      7'h1e: r = "2";
      7'h21: r = "c";
      7'h22: r = "x";
      7'h23: r = "d";
      7'h24: r = "e";
      7'h25: r = "4";
      7'h26: r = "3";
      7'h29: r = " ";
      7'h2a: r = "v";
      7'h2b: r = "f";
      7'h2c: r = "t";
      7'h2d: r = "r";
      7'h2e: r = "5";
      7'h31: r = "n";
      7'h32: r = "b";
      7'h33: r = "h";
      7'h34: r = "g";
      7'h35: r = "y";
      7'h36: r = "6";
      7'h3a: r = "m";
      7'h3b: r = "j";
      7'h3c: r = "u";
      7'h3d: r = "7";
      7'h3e: r = "8";
      7'h41: r = ",";
      7'h42: r = "k";
      7'h43: r = "i";
      7'h44: r = "o";
      7'h45: r = "0";
      7'h46: r = "9";
      7'h49: r = ".";
      7'h4a: r = "/";
      7'h4b: r = "l";
      7'h4c: r = ";";
      7'h4d: r = "p";
      7'h4e: r = "-";
      7'h52: r = 8'h27;
      7'h54: r = "[";
      7'h55: r = "=";
      7'h5a: r = 8'd10;
      7'h5b: r = "]";
      7'h5d: r = 8'h5c;
      7'h76: r = 8'd27;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ps2_set2_scancode_to_ascii.sv @@
// ps2_set2_scancode_to_ascii: top level, input register, decoder and result register
//
// channel  direction  handshake                  payload
// in       input      in_valid_i / in_stall_o    scan_byte_i  [7:0]
// out      output     out_valid_o / out_stall_i  keyval_o     [7:0]
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i [2:0], cfg_data_i [7:0]
//
// one request per cycle sustained while the output does not stall
// an accepted byte is held in the input register, then loads the result register
// the decode of a byte sits between the input register and the result register
// reset clears the flags, the valid bits and restores the default registers
// a stall on a full output holds it; the input register then fills and stalls the input
`default_nettype none

module ps2_set2_scancode_to_ascii (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [ps2sa_pkg::ByteW-1:0]   scan_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [ps2sa_pkg::ByteW-1:0]        keyval_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ps2sa_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ps2sa_pkg::ByteW-1:0]   cfg_data_i
);

  ps2sa_pkg::cfg_t cfg;

  logic                        in_vld_q;
  logic [ps2sa_pkg::ByteW-1:0] in_byte_q;
  logic                        out_vld_q;
  logic [ps2sa_pkg::ByteW-1:0] out_key_q;
  logic [ps2sa_pkg::ByteW-1:0] dec_key;
  logic                        out_free;
  logic                        step;
  logic                        in_take;

  assign out_free = !out_vld_q || !out_stall_i;
  assign step = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take = in_valid_i && !in_stall_o;

  ps2sa_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ps2sa_dec u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .scan_byte_i (in_byte_q),
    .cfg_i       (cfg),
    .keyval_o    (dec_key)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= scan_byte_i;
    end
    if (step) begin
      out_key_q <= dec_key;
    end
  end

  assign out_valid_o = out_vld_q;
  assign keyval_o = out_key_q;

endmodule

`default_nettype wire

@@ rtl/core/ps2sa_cfg.sv @@
// ps2sa_cfg: configuration register file for modifier scan bytes and key codes
`default_nettype none

module ps2sa_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ps2sa_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ps2sa_pkg::ByteW-1:0]   cfg_data_i,
  output ps2sa_pkg::cfg_t                    cfg_o
);

  ps2sa_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (ps2sa_pkg::cfg_idx_e'(cfg_index_i))
        ps2sa_pkg::CFG_LEFT_SHIFT_SCAN:  cfg_d.left_shift_scan = cfg_data_i;
        ps2sa_pkg::CFG_RIGHT_SHIFT_SCAN: cfg_d.right_shift_scan = cfg_data_i;
        ps2sa_pkg::CFG_CAPS_SCAN:        cfg_d.caps_scan = cfg_data_i;
        ps2sa_pkg::CFG_LEFT_SHIFT_KEY:   cfg_d.left_shift_key = cfg_data_i;
        ps2sa_pkg::CFG_RIGHT_SHIFT_KEY:  cfg_d.right_shift_key = cfg_data_i;
        ps2sa_pkg::CFG_CAPS_KEY:         cfg_d.caps_key = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_shift_scan <= 8'h12;
      cfg_q.right_shift_scan <= 8'h59;
      cfg_q.caps_scan <= 8'h58;
      cfg_q.left_shift_key <= 8'h80;
      cfg_q.right_shift_key <= 8'h81;
      cfg_q.caps_key <= 8'h82;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/ps2sa_dec.sv @@
// ps2sa_dec: modifier and release flags plus the scan byte to key code logic
`default_nettype none

module ps2sa_dec (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic [ps2sa_pkg::ByteW-1:0] scan_byte_i,
  input  ps2sa_pkg::cfg_t                  cfg_i,
  output logic [ps2sa_pkg::ByteW-1:0]      keyval_o
);

  logic lshift_q, lshift_d;
  logic rshift_q, rshift_d;
  logic caps_q, caps_d;
  logic rel_q, rel_d;
  logic [ps2sa_pkg::ByteW-1:0] key;
  logic [ps2sa_pkg::ByteW-1:0] lut;

  assign lut = ps2sa_pkg::set2_ascii(scan_byte_i[6:0]);

  always_comb begin
    lshift_d = lshift_q;
    rshift_d = rshift_q;
    caps_d = caps_q;
    rel_d = rel_q;
    key = '0;
    if (scan_byte_i == ps2sa_pkg::ScanExt0 || scan_byte_i == ps2sa_pkg::ScanExt1) begin
      key = '0;
    end else if (scan_byte_i == ps2sa_pkg::ScanRelease) begin
      rel_d = 1'b1;
    end else begin
      if (scan_byte_i == cfg_i.left_shift_scan) begin
        lshift_d = !rel_q;
        key = rel_q ? '0 : cfg_i.left_shift_key;
      end else if (scan_byte_i == cfg_i.right_shift_scan) begin
        rshift_d = !rel_q;
        key = rel_q ? '0 : cfg_i.right_shift_key;
      end else if (scan_byte_i == cfg_i.caps_scan) begin
        caps_d = caps_q ^ !rel_q;
        key = rel_q ? '0 : cfg_i.caps_key;
      end else if (scan_byte_i < ps2sa_pkg::TableLen && !rel_q) begin
        key = lut;
        if (lut >= ps2sa_pkg::AsciiLowA && lut <= ps2sa_pkg::AsciiLowZ &&
            ((lshift_q || rshift_q) != caps_q)) begin
          key = lut - ps2sa_pkg::CaseDelta;
        end
      end
      rel_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lshift_q <= 1'b0;
      rshift_q <= 1'b0;
      caps_q <= 1'b0;
      rel_q <= 1'b0;
    end else if (step_i) begin
      lshift_q <= lshift_d;
      rshift_q <= rshift_d;
      caps_q <= caps_d;
      rel_q <= rel_d;
    end
  end

  assign keyval_o = key;

endmodule

`default_nettype wire

@@ dv/ps2_set2_scancode_to_ascii_tb.sv @@
// ps2_set2_scancode_to_ascii_tb: checks key codes against a shadow decoder under random stalls
`timescale 1ns / 100ps

module ps2_set2_scancode_to_ascii_tb;

  localparam int unsigned NumPhases = 8;
  localparam int unsigned ItemsPerPhase = 125;
  localparam int unsigned HoldCycles = 64;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned DrainCycles = 8;

  typedef struct packed {
    logic [ps2sa_pkg::ByteW-1:0] scan;
    logic                        typed;
    logic [ps2sa_pkg::ByteW-1:0] key;
  } probe_t;

  localparam int unsigned NumProbes = 26;
  localparam probe_t Probes [NumProbes] = '{
    '{8'h00, 1'b1, 8'h00},
    '{8'hFF, 1'b1, 8'h00},
    '{8'h77, 1'b1, 8'h00},
    '{8'h76, 1'b1, 8'h1B},
    '{8'h5A, 1'b1, 8'h0A},
    '{8'h0D, 1'b1, 8'h09},
    '{8'h1C, 1'b1, 8'h61},
    '{8'h12, 1'b1, 8'h80},
    '{8'h1C, 1'b0, 8'h00},
    '{8'hF0, 1'b1, 8'h00},
    '{8'h12, 1'b1, 8'h00},
    '{8'h59, 1'b1, 8'h81},
    '{8'h15, 1'b0, 8'h00},
    '{8'hF0, 1'b1, 8'h00},
    '{8'h59, 1'b1, 8'h00},
    '{8'h58, 1'b1, 8'h82},
    '{8'h1A, 1'b0, 8'h00},
    '{8'h12, 1'b1, 8'h80},
    '{8'h1A, 1'b0, 8'h00},
    '{8'h16, 1'b0, 8'h00},
    '{8'hF0, 1'b1, 8'h00},
    '{8'hE0, 1'b1, 8'h00},
    '{8'hE1, 1'b1, 8'h00},
    '{8'h58, 1'b1, 8'h00},
    '{8'hF0, 1'b1, 8'h00},
    '{8'h12, 1'b1, 8'h00}
  };

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [ps2sa_pkg::ByteW-1:0]   scan_byte_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [ps2sa_pkg::ByteW-1:0]   keyval_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [ps2sa_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [ps2sa_pkg::ByteW-1:0]   cfg_data_i;

  ps2_set2_scancode_to_ascii dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .scan_byte_i (scan_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .keyval_o    (keyval_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  ps2sa_pkg::cfg_t             keymap;
  logic                        lsh_held;
  logic                        rsh_held;
  logic                        caps_locked;
  logic                        break_armed;
  logic [ps2sa_pkg::ByteW-1:0] key_fifo [$];
  int                          mismatches;
  bit                          quiet;
  bit                          hold_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [ps2sa_pkg::ByteW-1:0] set2_glyph(
      input logic [ps2sa_pkg::ByteW-1:0] code);
    logic [ps2sa_pkg::ByteW-1:0] g;
    g = '0;
    case (code)
      8'h0d: g = 8'd9;
      8'h0e: g = 8'h60;
      8'h15: g = "q";
      8'h16: g = "1";
      8'h1a: g = "z";
      8'h1b: g = "s";
      8'h1c: g = "a";
      8'h1d: g = "w";
      8'h1e: g = "2";
      8'h21: g = "c";
      8'h22: g = "x";
      8'h23: g = "d";
      8'h24: g = "e";
      8'h25: g = "4";
      8'h26: g = "3";
      8'h29: g = " ";
      8'h2a: g = "v";
      8'h2b: g = "f";
      8'h2c: g = "t";
      8'h2d: g = "r";
      8'h2e: g = "5";
      8'h31: g = "n";
      8'h32: g = "b";
      8'h33: g = "h";
      8'h34: g = "g";
      8'h35: g = "y";
      8'h36: g = "6";
      8'h3a: g = "m";
      8'h3b: g = "j";
      8'h3c: g = "u";
      8'h3d: g = "7";
      8'h3e: g = "8";
      8'h41: g = ",";
      8'h42: g = "k";
      8'h43: g = "i";
      8'h44: g = "o";
      8'h45: g = "0";
      8'h46: g = "9";
      8'h49: g = ".";
      8'h4a: g = "/";
      8'h4b: g = "l";
      8'h4c: g = ";";
      8'h4d: g = "p";
      8'h4e: g = "-";
      8'h52: g = 8'h27;
      8'h54: g = "[";
      8'h55: g = "=";
      8'h5a: g = 8'd10;
      8'h5b: g = "]";
      8'h5d: g = 8'h5c;
      8'h76: g = 8'd27;
      default: g = '0;
    endcase
    return g;
  endfunction

  function automatic logic [ps2sa_pkg::ByteW-1:0] decode_scan(
      input logic [ps2sa_pkg::ByteW-1:0] b);
    logic [ps2sa_pkg::ByteW-1:0] k;
    logic                        brk;
    k = '0;
    brk = break_armed;
    if (b == ps2sa_pkg::ScanExt0 || b == ps2sa_pkg::ScanExt1) begin
      k = '0;
    end else if (b == ps2sa_pkg::ScanRelease) begin
      break_armed = 1'b1;
    end else begin
      if (b == keymap.left_shift_scan) begin
        lsh_held = !brk;
        k = brk ? '0 : keymap.left_shift_key;
      end else if (b == keymap.right_shift_scan) begin
        rsh_held = !brk;
        k = brk ? '0 : keymap.right_shift_key;
      end else if (b == keymap.caps_scan) begin
        if (!brk) caps_locked = !caps_locked;
        k = brk ? '0 : keymap.caps_key;
      end else if (b < ps2sa_pkg::TableLen && !brk) begin
        k = set2_glyph(b);
        if (k >= ps2sa_pkg::AsciiLowA && k <= ps2sa_pkg::AsciiLowZ &&
            ((lsh_held || rsh_held) != caps_locked))
          k = k - ps2sa_pkg::CaseDelta;
      end
      break_armed = 1'b0;
    end
    return k;
  endfunction

  task automatic report_mismatch(input string what, input logic [ps2sa_pkg::ByteW-1:0] got,
                                 input logic [ps2sa_pkg::ByteW-1:0] want);
    mismatches++;
    $display("%0t mismatch: %s got %02h want %02h", $realtime, what, got, want);
  endtask

  function automatic bit gap_now();
    return !quiet && ($urandom_range(99) < 37);
  endfunction

  task automatic push_scan(input logic [ps2sa_pkg::ByteW-1:0] b, input logic typed,
                           input logic [ps2sa_pkg::ByteW-1:0] want);
    logic [ps2sa_pkg::ByteW-1:0] pred;
    while (gap_now()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    scan_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = decode_scan(b);
    key_fifo.push_back(typed ? want : pred);
  endtask

  task automatic send_keystroke(output int n);
    logic [ps2sa_pkg::ByteW-1:0] code;
    int                          sel;
    n = 0;
    if ($urandom_range(99) < 12) begin
      push_scan(8'($urandom_range(255)), 1'b0, '0);
      n = 1;
    end else begin
      sel = $urandom_range(99);
      if (sel < 30) begin
        case ($urandom_range(2))
          0: code = keymap.left_shift_scan;
          1: code = keymap.right_shift_scan;
          default: code = keymap.caps_scan;
        endcase
      end else if (sel < 85) begin
        code = 8'($urandom_range(8'h76));
      end else begin
        code = 8'($urandom_range(255));
      end
      if ($urandom_range(9) == 0) begin
        push_scan(ps2sa_pkg::ScanExt0, 1'b0, '0);
        n++;
      end
      if ($urandom_range(3) == 0) begin
        push_scan(ps2sa_pkg::ScanRelease, 1'b0, '0);
        n++;
      end
      push_scan(code, 1'b0, '0);
      n++;
    end
  endtask

  task automatic write_reg(input ps2sa_pkg::cfg_idx_e idx,
                           input logic [ps2sa_pkg::ByteW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      ps2sa_pkg::CFG_LEFT_SHIFT_SCAN:  keymap.left_shift_scan = val;
      ps2sa_pkg::CFG_RIGHT_SHIFT_SCAN: keymap.right_shift_scan = val;
      ps2sa_pkg::CFG_CAPS_SCAN:        keymap.caps_scan = val;
      ps2sa_pkg::CFG_LEFT_SHIFT_KEY:   keymap.left_shift_key = val;
      ps2sa_pkg::CFG_RIGHT_SHIFT_KEY:  keymap.right_shift_key = val;
      ps2sa_pkg::CFG_CAPS_KEY:         keymap.caps_key = val;
      default: ;
    endcase
  endtask

  task automatic program_phase(input int phase);
    logic [ps2sa_pkg::ByteW-1:0] vals [6];
    logic [ps2sa_pkg::ByteW-1:0] shared;
    shared = 8'($urandom_range(8'h76));
    for (int i = 0; i < 6; i++) begin
      if (i < 3)
        vals[i] = ($urandom_range(1) == 0) ? 8'($urandom_range(8'h76)) : 8'($urandom_range(255));
      else
        vals[i] = 8'($urandom_range(255));
    end
    case (phase)
      1: for (int i = 0; i < 6; i++) vals[i] = 8'h00;
      2: for (int i = 0; i < 6; i++) vals[i] = 8'hFF;
      3: begin
        vals[0] = ps2sa_pkg::ScanRelease;
        vals[1] = ps2sa_pkg::ScanExt0;
        vals[2] = ps2sa_pkg::ScanExt1;
      end
      4: for (int i = 0; i < 3; i++) vals[i] = shared;
      7: vals = '{8'h12, 8'h59, 8'h58, 8'h80, 8'h81, 8'h82};
      default: ;
    endcase
    for (int i = 0; i < 6; i++) write_reg(ps2sa_pkg::cfg_idx_e'(i), vals[i]);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (key_fifo.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_keys
    logic [ps2sa_pkg::ByteW-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (key_fifo.size() == 0) begin
        report_mismatch("key with no request", keyval_o, '0);
      end else begin
        want = key_fifo.pop_front();
        if (keyval_o !== want) report_mismatch("keyval", keyval_o, want);
      end
    end
  end

  initial begin : sink
    int hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold_left == 0) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 37);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[ps2_set2_scancode_to_ascii] ERROR");
    $finish;
  end

  initial begin : stimulus
    int sent;
    int n;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    scan_byte_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    mismatches  = 0;
    keymap      = '{8'h12, 8'h59, 8'h58, 8'h80, 8'h81, 8'h82};
    lsh_held    = 1'b0;
    rsh_held    = 1'b0;
    caps_locked = 1'b0;
    break_armed = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumProbes; i++) push_scan(Probes[i].scan, Probes[i].typed, Probes[i].key);

    for (int phase = 0; phase < NumPhases; phase++) begin
      in_valid_i <= 1'b0;
      wait_drained();
      program_phase(phase);
      quiet = (phase == 6);
      if (phase == 5) hold_req = 1'b1;
      sent = 0;
      while (sent < ItemsPerPhase) begin
        send_keystroke(n);
        sent += n;
      end
    end
    in_valid_i <= 1'b0;

    while (key_fifo.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (key_fifo.size() != 0) report_mismatch("requests left without key", '0, '0);
    if (mismatches == 0)
      $display("[ps2_set2_scancode_to_ascii] OK");
    else
      $display("[ps2_set2_scancode_to_ascii] ERROR");
    $finish;
  end

endmodule
